### src/keyed_quantity_table_macros.svh
// Assertion macros for the keyed quantity table.
// Taken in by the top level; depends on nothing else.
`ifndef KEYED_QUANTITY_TABLE_MACROS_SVH
`define KEYED_QUANTITY_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define KQT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keyed_quantity_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define KQT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keyed_quantity_table: next-cycle check failed");

`endif

### src/kqt_pkg.sv
// Shared types, constants and status codes of the keyed quantity table.
// Used by the controller, the datapath and the top level; depends on nothing.
package kqt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W  = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int QTY_W   = 31;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 4;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [USED_W-1:0] t_used;
    typedef logic [QTY_W-1:0]  t_qty;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_qty QTY_MAX = {QTY_W{1'b1}};

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam t_status ST_ADDED     = 3'd0;
    localparam t_status ST_INSERTED  = 3'd1;
    localparam t_status ST_REMOVED   = 3'd2;
    localparam t_status ST_INSUFF    = 3'd3;
    localparam t_status ST_NOTFOUND  = 3'd4;
    localparam t_status ST_FULL      = 3'd5;
    localparam t_status ST_SATURATED = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request beat
        logic first;      // read address is slot zero
        logic rd_en;      // update the registered read data
        logic idx_inc;    // advance the scan index
        logic exec_hit;   // apply the request to the matching entry
        logic exec_miss;  // apply the request with no matching entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;      // stored key at the scan index equals the request key
        logic last;       // scan index is the last used entry
        logic empty;      // no entries in use
    } t_sts;

endpackage

### src/keyed_quantity_table.sv
// Top level of the keyed quantity table: a bounded table of key and quantity pairs.
// Depends on kqt_pkg, kqt_ctrl, kqt_dp and keyed_quantity_table_macros.svh.
// Usage: a request beat (i_kind, i_item_key, i_amount) is taken at a rising
// clock edge where start is high and busy is low. An add for a stored key adds
// to its quantity, saturating at the largest 31-bit value; an add for a new key
// appends an entry unless the table is full. A remove subtracts only when the
// stored quantity covers the amount. Every request produces exactly one result
// beat (o_status, o_slot, o_quantity_after), shown for one cycle with o_valid.
// The receiver cannot stall; the result is simply taken in that cycle.
//
// Timing: the controller scans the used entries one per cycle through the
// registered read port of the key memory, then applies the update in its hit or
// miss state. A hit ends the scan at the matching entry; a miss scans every
// used entry, and an empty table goes straight to the update. The result is
// registered after the update. busy drops as the result is registered, so the
// next request may be accepted in the cycle that o_valid is shown.
// Reset (i_rst_n low, synchronous) empties the table and idles the controller;
// stored entries are not cleared, since only those below the fill count are read.
`include "keyed_quantity_table_macros.svh"

module keyed_quantity_table
    import kqt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic signed [31:0] i_item_key,
    input  logic [30:0]        i_amount,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [3:0]         o_slot,
    output logic [30:0]        o_quantity_after
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer: accepts the request, steps the scan and selects the update.
    kqt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Storage, compare, add and subtract, and the result register.
    kqt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_kind           (i_kind),
        .i_item_key       (i_item_key),
        .i_amount         (i_amount),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_quantity_after (o_quantity_after)
    );

    // An accepted request keeps the block busy in the next cycle.
    `KQT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // Each update cycle produces a result beat in the following cycle.
    `KQT_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, cmd.exec_hit || cmd.exec_miss, o_valid)

    // A request that touched no entry reports slot and quantity as zero.
    `KQT_ASSERT_NOW(a_none_zero, i_clk, i_rst_n,
        o_valid && (o_status == ST_NOTFOUND || o_status == ST_FULL),
        o_slot == '0 && o_quantity_after == '0)

    // Loading, and the two kinds of update, never overlap.
    `KQT_ASSERT_NOW(a_cmd_exclusive, i_clk, i_rst_n, 1'b1,
        $onehot0({cmd.load, cmd.exec_hit, cmd.exec_miss}))

endmodule

### src/kqt_ctrl.sv
// Controller state machine of the keyed quantity table.
// Depends on kqt_pkg; drives the datapath through t_cmd and reads t_sts.
module kqt_ctrl
    import kqt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HIT  = 2'd2;
    localparam logic [1:0] S_MISS = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.first = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    n_state     = i_sts.empty ? S_MISS : S_SCAN;
                end
            end
            S_SCAN: begin
                // The read data holds the entry at the scan index.
                if (i_sts.match) begin
                    n_state = S_HIT;
                end else if (i_sts.last) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_HIT: begin
                o_cmd.exec_hit = 1'b1;
                n_state        = S_IDLE;
            end
            S_MISS: begin
                o_cmd.exec_miss = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

### src/kqt_dp.sv
// Datapath of the keyed quantity table: key and quantity memories, scan index,
// fill count and the registered result. Depends on kqt_pkg.
module kqt_dp
    import kqt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_kind,
    input  logic signed [31:0] i_item_key,
    input  logic [30:0]        i_amount,
    output t_sts               o_sts,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [3:0]         o_slot,
    output logic [30:0]        o_quantity_after
);

    logic [KEY_W-1:0] key_mem [ENTRIES];
    t_qty             qty_mem [ENTRIES];

    logic             r_kind;
    logic [KEY_W-1:0] r_key;
    t_qty             r_amount;
    t_idx             r_idx;
    t_used            r_used;
    logic [KEY_W-1:0] r_key_rd;
    t_qty             r_qty_rd;
    logic             r_valid;
    t_status          r_status;
    t_slot            r_slot;
    t_qty             r_qty_out;

    t_idx             rd_addr;
    logic             wr_en;
    t_idx             wr_addr;
    logic             key_wr;
    t_qty             wr_qty;
    t_status          n_status;
    t_slot            n_slot;
    t_qty             n_qty_out;
    logic             used_inc;
    logic [QTY_W:0]   sum;
    t_qty             diff;

    assign rd_addr = i_cmd.first ? '0 : t_idx'(r_idx + 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_key    <= i_item_key;
            r_amount <= i_amount;
        end
        if (i_cmd.first) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= rd_addr;
        end
        if (i_cmd.rd_en) begin
            r_key_rd <= key_mem[rd_addr];
            r_qty_rd <= qty_mem[rd_addr];
        end
        if (wr_en) begin
            qty_mem[wr_addr] <= wr_qty;
            if (key_wr) begin
                key_mem[wr_addr] <= r_key;
            end
        end
    end

    assign o_sts.match = (r_key_rd == r_key);
    assign o_sts.last  = (USED_W'(r_idx) == t_used'(r_used - 1'b1));
    assign o_sts.empty = (r_used == '0);

    assign sum  = {1'b0, r_qty_rd} + {1'b0, r_amount};
    assign diff = r_qty_rd - r_amount;

    always_comb begin
        wr_en     = 1'b0;
        key_wr    = 1'b0;
        wr_addr   = r_idx;
        wr_qty    = r_qty_rd;
        used_inc  = 1'b0;
        n_status  = ST_NOTFOUND;
        n_slot    = '0;
        n_qty_out = '0;
        if (i_cmd.exec_hit) begin
            n_slot = SLOT_W'(r_idx);
            wr_en  = 1'b1;
            if (r_kind == KIND_ADD) begin
                if (sum[QTY_W]) begin
                    wr_qty   = QTY_MAX;
                    n_status = ST_SATURATED;
                end else begin
                    wr_qty   = sum[QTY_W-1:0];
                    n_status = ST_ADDED;
                end
            end else if (r_qty_rd >= r_amount) begin
                wr_qty   = diff;
                n_status = ST_REMOVED;
            end else begin
                n_status = ST_INSUFF;
            end
            n_qty_out = wr_qty;
        end else if (i_cmd.exec_miss && r_kind == KIND_ADD) begin
            if (r_used == t_used'(ENTRIES)) begin
                n_status = ST_FULL;
            end else begin
                wr_en     = 1'b1;
                key_wr    = 1'b1;
                wr_addr   = r_used[IDX_W-1:0];
                wr_qty    = r_amount;
                used_inc  = 1'b1;
                n_status  = ST_INSERTED;
                n_slot    = SLOT_W'(r_used);
                n_qty_out = r_amount;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec_hit | i_cmd.exec_miss;
            if (used_inc) begin
                r_used <= t_used'(r_used + 1'b1);
            end
        end
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_qty_out <= n_qty_out;
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_slot           = r_slot;
    assign o_quantity_after = r_qty_out;

endmodule
